// File: rtl/core/lss_pkg.sv
// Shared constants, codes and controller/datapath link types for the LIFO stack.
`timescale 1ns / 1ps

package lss_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int WORD_W      = 32;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int FILL_W      = 7;
	localparam int MDEPTH_W    = 6;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_FIND  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RD_POP   = 2'd0,
		RD_FIRST = 2'd1,
		RD_NEXT  = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    capture;
		logic    push;
		logic    pop;
		logic    clear;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    top_load;
		logic    emit;
		status_t status;
		logic    found;
	} lss_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic cnt_full;
		logic match;
		logic scan_last;
	} lss_sts_t;

endpackage

// File: rtl/core/lss_ifs.sv
// Valid/ready channel interfaces for stack requests and results.
`timescale 1ns / 1ps

interface lss_req_if;
	logic                                valid;
	logic                                ready;
	logic [lss_pkg::KIND_W-1:0]          kind;
	logic signed [lss_pkg::WORD_W-1:0]   data_value;

	modport source (output valid, output kind, output data_value, input ready);
	modport sink (input valid, input kind, input data_value, output ready);
endinterface

interface lss_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [lss_pkg::STATUS_W-1:0]        status;
	logic signed [lss_pkg::WORD_W-1:0]   top_value;
	logic                                is_empty;
	logic [lss_pkg::FILL_W-1:0]          fill_level;
	logic                                match_found;
	logic [lss_pkg::MDEPTH_W-1:0]        match_depth;

	modport source (output valid, output status, output top_value, output is_empty,
		output fill_level, output match_found, output match_depth, input ready);
	modport sink (input valid, input status, input top_value, input is_empty,
		input fill_level, input match_found, input match_depth, output ready);
endinterface

// File: rtl/core/lss_dpath.sv
// Stack datapath: entry memory, fill count, top word, search pointer, result register.
`timescale 1ns / 1ps

module lss_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lss_pkg::lss_cmd_t                   cmd,
	output lss_pkg::lss_sts_t                   sts,
	input  logic signed [lss_pkg::WORD_W-1:0]   data_value,
	output logic [lss_pkg::STATUS_W-1:0]        status,
	output logic signed [lss_pkg::WORD_W-1:0]   top_value,
	output logic                                is_empty,
	output logic [lss_pkg::FILL_W-1:0]          fill_level,
	output logic                                match_found,
	output logic [lss_pkg::MDEPTH_W-1:0]        match_depth
);

	logic [lss_pkg::WORD_W-1:0] mem [lss_pkg::STACK_DEPTH];

	logic [lss_pkg::WORD_W-1:0] key_q;
	logic [lss_pkg::WORD_W-1:0] top_q;
	logic [lss_pkg::WORD_W-1:0] rd_data_q;
	logic [lss_pkg::CNT_W-1:0]  count_q;
	logic [lss_pkg::ADDR_W-1:0] scan_addr_q;
	logic [lss_pkg::ADDR_W-1:0] scan_d_q;

	logic [lss_pkg::CNT_W-1:0]  count_d;
	logic [lss_pkg::WORD_W-1:0] top_d;
	logic [lss_pkg::CNT_W-1:0]  cnt_m1;
	logic [lss_pkg::CNT_W-1:0]  cnt_m2;
	logic [lss_pkg::ADDR_W-1:0] raddr;

	assign cnt_m1 = count_q - lss_pkg::CNT_W'(1);
	assign cnt_m2 = count_q - lss_pkg::CNT_W'(2);

	always_comb begin
		case (cmd.rd_sel)
			lss_pkg::RD_POP:   raddr = cnt_m2[lss_pkg::ADDR_W-1:0];
			lss_pkg::RD_FIRST: raddr = cnt_m1[lss_pkg::ADDR_W-1:0];
			lss_pkg::RD_NEXT:  raddr = scan_addr_q - lss_pkg::ADDR_W'(1);
			default:           raddr = scan_addr_q;
		endcase
	end

	// State as it stands once the current command has taken effect
	always_comb begin
		count_d = count_q;
		if (cmd.push) begin
			count_d = count_q + lss_pkg::CNT_W'(1);
		end else if (cmd.pop) begin
			count_d = cnt_m1;
		end else if (cmd.clear) begin
			count_d = '0;
		end
	end

	always_comb begin
		top_d = top_q;
		if (cmd.push) begin
			top_d = key_q;
		end else if (cmd.top_load) begin
			top_d = rd_data_q;
		end
	end

	assign sts.cnt_zero  = (count_q == '0);
	assign sts.cnt_one   = (count_q == lss_pkg::CNT_W'(1));
	assign sts.cnt_full  = (count_q == lss_pkg::CNT_W'(lss_pkg::STACK_DEPTH));
	assign sts.match     = (rd_data_q == key_q);
	assign sts.scan_last = (scan_addr_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= data_value;
		end
		top_q <= top_d;
		if (cmd.rd_en) begin
			scan_addr_q <= raddr;
			if (cmd.rd_sel == lss_pkg::RD_FIRST) begin
				scan_d_q <= '0;
			end else if (cmd.rd_sel == lss_pkg::RD_NEXT) begin
				scan_d_q <= scan_d_q + lss_pkg::ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[lss_pkg::ADDR_W-1:0]] <= key_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status      <= cmd.status;
			top_value   <= (count_d == '0) ? '1 : top_d;
			is_empty    <= (count_d == '0);
			fill_level  <= lss_pkg::FILL_W'(count_d);
			match_found <= cmd.found;
			match_depth <= cmd.found ? lss_pkg::MDEPTH_W'(scan_d_q) : '0;
		end
	end

endmodule

// File: rtl/core/lss_ctrl.sv
// Stack controller: request handshake, operation sequencing, result valid.
`timescale 1ns / 1ps

module lss_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [lss_pkg::KIND_W-1:0] req_kind,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output lss_pkg::lss_cmd_t          cmd,
	input  lss_pkg::lss_sts_t          sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP_RD,
		S_SCAN
	} state_t;

	state_t          state_q;
	state_t          state_d;
	lss_pkg::kind_t  kind_q;
	logic            rsp_valid_q;
	logic            slot_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = lss_pkg::RD_POP;
		cmd.status = lss_pkg::ST_OK;
		state_d    = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			// Start only once the result register is free; later states then emit freely
			S_EXEC: begin
				if (slot_free) begin
					state_d = S_IDLE;
					case (kind_q)
						lss_pkg::KIND_PUSH: begin
							cmd.emit = 1'b1;
							if (sts.cnt_full) begin
								cmd.status = lss_pkg::ST_PUSH_FULL;
							end else begin
								cmd.push = 1'b1;
							end
						end
						lss_pkg::KIND_POP: begin
							if (sts.cnt_zero) begin
								cmd.emit   = 1'b1;
								cmd.status = lss_pkg::ST_POP_EMPTY;
							end else if (sts.cnt_one) begin
								cmd.emit = 1'b1;
								cmd.pop  = 1'b1;
							end else begin
								cmd.pop    = 1'b1;
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = lss_pkg::RD_POP;
								state_d    = S_POP_RD;
							end
						end
						lss_pkg::KIND_CLEAR: begin
							cmd.emit  = 1'b1;
							cmd.clear = 1'b1;
						end
						lss_pkg::KIND_FIND: begin
							if (sts.cnt_zero) begin
								cmd.emit = 1'b1;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = lss_pkg::RD_FIRST;
								state_d    = S_SCAN;
							end
						end
						default: begin
							cmd.emit = 1'b1;
						end
					endcase
				end
			end
			S_POP_RD: begin
				cmd.top_load = 1'b1;
				cmd.emit     = 1'b1;
				state_d      = S_IDLE;
			end
			// Compare the entry read last cycle, fetch the next one below it
			S_SCAN: begin
				if (sts.match) begin
					cmd.emit  = 1'b1;
					cmd.found = 1'b1;
					state_d   = S_IDLE;
				end else if (sts.scan_last) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = lss_pkg::RD_NEXT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= lss_pkg::KIND_PUSH;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				kind_q <= lss_pkg::kind_t'(req_kind);
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/lifo_stack_with_search_core.sv
// Top level: bounded LIFO stack of 32-bit words with search from the top.
// Push, clear, pop to empty and any op on an empty stack emit directly; pop
// leaving entries first reads the new top word; find compares entries from
// the top down until a hit or the bottom (one memory read per compared entry).
// One item is in flight at a time: a new request is taken only once the last
// one has produced its result. Reset clears the fill count and the handshake
// state; the entry memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module lifo_stack_with_search_core (
	input  logic       clk,
	input  logic       arst_n,
	lss_req_if.sink    req,
	lss_rsp_if.source  rsp
);

	lss_pkg::lss_cmd_t cmd;
	lss_pkg::lss_sts_t sts;

	lss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_kind  (req.kind),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lss_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.data_value  (req.data_value),
		.status      (rsp.status),
		.top_value   (rsp.top_value),
		.is_empty    (rsp.is_empty),
		.fill_level  (rsp.fill_level),
		.match_found (rsp.match_found),
		.match_depth (rsp.match_depth)
	);

endmodule
